// ===== src/flash_block_rotation_cache_assert.svh =====
// Assertion macros for the flash block rotation cache.
// Expects clk and arst_n in the scope of each use.
`ifndef FLASH_BLOCK_ROTATION_CACHE_ASSERT_SVH
`define FLASH_BLOCK_ROTATION_CACHE_ASSERT_SVH

// same-cycle implication
`define FBRC_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FBRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/fbrc_pkg.sv =====
// Shared types and codes for the flash block rotation cache.
// No dependencies.
package fbrc_pkg;

	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_FLUSH = 2'd2;
	localparam logic [1:0] REQ_LOAD  = 2'd3;

	localparam logic [1:0] KIND_READ    = 2'd0;
	localparam logic [1:0] KIND_ACK     = 2'd1;
	localparam logic [1:0] KIND_ERASE   = 2'd2;
	localparam logic [1:0] KIND_PROGRAM = 2'd3;

	localparam logic [1:0] CFG_FLASH_BASE   = 2'd0;
	localparam logic [1:0] CFG_INITIAL_SLOT = 2'd1;
	localparam logic [1:0] CFG_ERASE_SECTOR = 2'd2;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_FLUSH = 2'd2,
		OP_LOAD  = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  word_index;
		logic [31:0] word_value;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] flash_address;
		logic [31:0] payload;
		logic        last;
	} res_t;

	typedef struct packed {
		op_t         op;
		logic        in_range;
		logic [7:0]  idx;
		logic [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic [31:0] flash_base;
		logic [3:0]  erase_sector;
		logic        slot_load;
		logic [4:0]  slot_init;
	} cfg_t;

endpackage

// ===== src/fbrc_front.sv =====
// Front end: takes requests, decodes and range-checks them, and holds them
// in a two-entry queue for the back end. Uses fbrc_pkg.
module fbrc_front #(
	parameter int BLOCK_WORDS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  fbrc_pkg::req_t  request,
	output logic            busy,
	output logic            cmd_valid,
	output fbrc_pkg::cmd_t  cmd,
	input  logic            cmd_pop
);
	import fbrc_pkg::*;

	cmd_t       queue_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	cmd_t       decoded;

	always_comb begin
		decoded.in_range = request.word_index < 8'(BLOCK_WORDS);
		decoded.idx      = request.word_index;
		decoded.value    = request.word_value;
		unique case (request.req_type)
			REQ_READ:  decoded.op = OP_READ;
			REQ_WRITE: decoded.op = OP_WRITE;
			REQ_FLUSH: decoded.op = OP_FLUSH;
			default:   decoded.op = OP_LOAD;
		endcase
	end

	assign busy      = count_q == 2'd2;
	assign push      = start && !busy;
	assign cmd_valid = count_q != 2'd0;
	assign cmd       = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && cmd_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= decoded;
		end
	end

endmodule

// ===== src/fbrc_back.sv =====
// Back end: word cache memory, dirty mark, slot and flush sequencer.
// Emits one result per cycle through two register stages. Uses fbrc_pkg.
module fbrc_back #(
	parameter int BLOCK_WORDS = 32,
	parameter int BLOCK_COUNT = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  fbrc_pkg::cmd_t  cmd,
	output logic            cmd_pop,
	input  fbrc_pkg::cfg_t  cfg,
	output logic            result_valid,
	output fbrc_pkg::res_t  result
);
	import fbrc_pkg::*;

	localparam int IW        = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
	localparam int BLK_BYTES = BLOCK_WORDS * 4;

	typedef enum logic [2:0] {
		ST_RUN  = 3'b001,
		ST_PROG = 3'b010,
		ST_MARK = 3'b100
	} state_t;

	logic [31:0]   mem_q [BLOCK_WORDS];
	logic [31:0]   rdata_q;
	logic [IW-1:0] raddr;
	logic          mem_we;

	state_t        state_q;
	logic          dirty_q;
	logic [5:0]    slot_q;
	logic          erased_q;
	logic [31:0]   addr_q;
	logic [IW-1:0] cnt_q;

	logic          valid_s1;
	logic [1:0]    kind_s1;
	logic [31:0]   addr_s1;
	logic [31:0]   const_s1;
	logic          use_mem_s1;
	logic          last_s1;

	logic          valid_s2;
	res_t          res_s2;

	logic [6:0]    slot_next2;
	logic          erased_now;
	logic [6:0]    target;
	logic [31:0]   block_off;
	logic          cnt_last;

	assign cmd_pop    = cmd_valid && (state_q == ST_RUN);
	assign slot_next2 = {1'b0, slot_q} + 7'd2;
	assign erased_now = slot_next2 >= 7'(BLOCK_COUNT);
	assign target     = erased_now ? 7'd1 : slot_next2;
	assign block_off  = 32'(target) * 32'(BLK_BYTES);
	assign cnt_last   = cnt_q == IW'(BLOCK_WORDS - 1);
	assign mem_we     = cmd_pop && cmd.in_range && (cmd.op == OP_WRITE || cmd.op == OP_LOAD);

	always_comb begin
		if (state_q == ST_PROG) begin
			raddr = cnt_q;
		end else if (cmd.in_range) begin
			raddr = cmd.idx[IW-1:0];
		end else begin
			raddr = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[cmd.idx[IW-1:0]] <= cmd.value;
		end
		rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_RUN;
			dirty_q    <= 1'b0;
			slot_q     <= 6'd0;
			erased_q   <= 1'b0;
			addr_q     <= 32'd0;
			cnt_q      <= '0;
			valid_s1   <= 1'b0;
			kind_s1    <= KIND_ACK;
			addr_s1    <= 32'd0;
			const_s1   <= 32'd0;
			use_mem_s1 <= 1'b0;
			last_s1    <= 1'b0;
		end else begin
			valid_s1   <= 1'b0;
			addr_s1    <= 32'd0;
			const_s1   <= 32'd0;
			use_mem_s1 <= 1'b0;
			last_s1    <= 1'b1;
			kind_s1    <= KIND_ACK;
			if (cfg.slot_load) begin
				slot_q <= {1'b0, cfg.slot_init};
			end
			unique case (state_q)
				ST_RUN: begin
					if (cmd_pop) begin
						case (cmd.op)
							OP_READ: begin
								valid_s1   <= 1'b1;
								kind_s1    <= KIND_READ;
								use_mem_s1 <= cmd.in_range;
							end
							OP_WRITE: begin
								valid_s1 <= 1'b1;
								if (cmd.in_range) begin
									dirty_q <= 1'b1;
								end
							end
							OP_LOAD: begin
								valid_s1 <= 1'b1;
							end
							default: begin
								if (!dirty_q) begin
									valid_s1 <= 1'b1;
								end else begin
									erased_q <= erased_now;
									addr_q   <= cfg.flash_base + block_off;
									cnt_q    <= '0;
									state_q  <= ST_PROG;
									if (erased_now) begin
										valid_s1 <= 1'b1;
										kind_s1  <= KIND_ERASE;
										const_s1 <= 32'(cfg.erase_sector);
										last_s1  <= 1'b0;
									end
								end
							end
						endcase
					end
				end
				ST_PROG: begin
					valid_s1   <= 1'b1;
					kind_s1    <= KIND_PROGRAM;
					addr_s1    <= addr_q;
					use_mem_s1 <= 1'b1;
					last_s1    <= erased_q && cnt_last;
					addr_q     <= addr_q + 32'd4;
					cnt_q      <= cnt_q + IW'(1);
					if (cnt_last) begin
						if (erased_q) begin
							slot_q  <= 6'd0;
							dirty_q <= 1'b0;
							state_q <= ST_RUN;
						end else begin
							state_q <= ST_MARK;
						end
					end
				end
				ST_MARK: begin
					valid_s1 <= 1'b1;
					kind_s1  <= KIND_PROGRAM;
					addr_s1  <= cfg.flash_base + {24'd0, slot_q, 2'b00};
					slot_q   <= slot_q + 6'd1;
					dirty_q  <= 1'b0;
					state_q  <= ST_RUN;
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			res_s2   <= '0;
		end else begin
			valid_s2             <= valid_s1;
			res_s2.kind          <= kind_s1;
			res_s2.flash_address <= addr_s1;
			res_s2.payload       <= use_mem_s1 ? rdata_q : const_s1;
			res_s2.last          <= last_s1;
		end
	end

	assign result_valid = valid_s2;
	assign result       = res_s2;

endmodule

// ===== src/flash_block_rotation_cache.sv =====
// Top level of the flash block rotation cache: configuration registers,
// front end and back end. Uses fbrc_pkg, fbrc_front, fbrc_back.
//
// Each result passes the s1 and s2 registers after the back end picks up its
// request. Results come out one per cycle, each shown for exactly one cycle
// with result_valid; the receiver cannot stall them. Reads, writes, loads and
// clean flushes do not hold the back end, so one request per cycle is
// sustained while no dirty flush holds it. A dirty flush holds the back end
// through the erase, then one program per word when it erases, and otherwise
// a first step with no result, one program per word, then the marker write,
// reading one cache word per cycle from the single read port; a two-item
// queue keeps taking requests meanwhile and busy rises when it is full.
// Configuration writes are always taken (cfg_ready is high) and must be done
// while the block is idle.
module flash_block_rotation_cache #(
	parameter int BLOCK_WORDS = 32,
	parameter int BLOCK_COUNT = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  fbrc_pkg::req_t  request,
	output logic            result_valid,
	output fbrc_pkg::res_t  result,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_index,
	input  logic [31:0]     cfg_data
);
	import fbrc_pkg::*;

	`include "flash_block_rotation_cache_assert.svh"

	logic [31:0] flash_base_q;
	logic [3:0]  erase_sector_q;
	logic        cfg_we;
	cfg_t        cfg;
	logic        cmd_valid;
	logic        cmd_pop;
	cmd_t        cmd;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_base_q   <= 32'd0;
			erase_sector_q <= 4'd11;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FLASH_BASE:   flash_base_q   <= cfg_data;
				CFG_ERASE_SECTOR: erase_sector_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.flash_base   = flash_base_q;
		cfg.erase_sector = erase_sector_q;
		cfg.slot_load    = cfg_we && (cfg_index == CFG_INITIAL_SLOT);
		cfg.slot_init    = cfg_data[4:0];
	end

	fbrc_front #(
		.BLOCK_WORDS(BLOCK_WORDS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.request  (request),
		.busy     (busy),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop)
	);

	fbrc_back #(
		.BLOCK_WORDS(BLOCK_WORDS),
		.BLOCK_COUNT(BLOCK_COUNT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop),
		.cfg         (cfg),
		.result_valid(result_valid),
		.result      (result)
	);

	`FBRC_ASSERT_IMPLY(a_single_last, result_valid && (result.kind == KIND_READ || result.kind == KIND_ACK), result.last, "read or ack without last")
	`FBRC_ASSERT_IMPLY(a_addr_zero, result_valid && result.kind != KIND_PROGRAM, result.flash_address == 32'd0, "nonzero address on non-program item")
	`FBRC_ASSERT_IMPLY(a_erase_not_last, result_valid && result.kind == KIND_ERASE, !result.last, "erase marked last")
	`FBRC_ASSERT_NEXT(a_erase_then_prog, result_valid && result.kind == KIND_ERASE, result_valid && result.kind == KIND_PROGRAM, "erase not followed by program")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for flash_block_rotation_cache: predicts read data, acks
// and flush command streams per item and checks the result stream in order.
// Depends on fbrc_pkg and the RTL under src/.
module tb_top;
	import fbrc_pkg::*;

	localparam int BLOCK_WORDS = 32;
	localparam int BLOCK_COUNT = 32;
	localparam int STALL_LIMIT = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	req_t        request = '0;
	logic        result_valid;
	res_t        result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	req_t        req_backlog[$];
	res_t        due_results[$];
	int          gap_pct = 12;
	int          n_bad = 0;
	int          n_seen = 0;

	// mirror of the block's state and registers
	logic [31:0] cache_m[BLOCK_WORDS];
	logic        dirty_m = 1'b0;
	logic [5:0]  slot_m = '0;
	logic [31:0] base_m = '0;
	logic [3:0]  sector_m = 4'd11;

	flash_block_rotation_cache #(
		.BLOCK_WORDS(BLOCK_WORDS),
		.BLOCK_COUNT(BLOCK_COUNT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.result_valid(result_valid),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic res_t make_result(logic [1:0] kind, logic [31:0] addr,
			logic [31:0] data, logic fin);
		res_t r;
		r.kind = kind;
		r.flash_address = addr;
		r.payload = data;
		r.last = fin;
		return r;
	endfunction

	function automatic void predict_request(req_t r);
		logic        in_range;
		logic        wraps;
		logic [31:0] blk_addr;
		int          target;
		in_range = r.word_index < BLOCK_WORDS;
		case (op_t'(r.req_type))
			OP_READ: begin
				due_results.push_back(make_result(KIND_READ, '0,
					in_range ? cache_m[r.word_index] : 32'd0, 1'b1));
			end
			OP_WRITE, OP_LOAD: begin
				if (in_range) begin
					cache_m[r.word_index] = r.word_value;
					if (op_t'(r.req_type) == OP_WRITE)
						dirty_m = 1'b1;
				end
				due_results.push_back(make_result(KIND_ACK, '0, '0, 1'b1));
			end
			default: begin
				if (!dirty_m) begin
					due_results.push_back(make_result(KIND_ACK, '0, '0, 1'b1));
				end else begin
					wraps = (int'(slot_m) + 2) >= BLOCK_COUNT;
					target = wraps ? 1 : int'(slot_m) + 2;
					blk_addr = base_m + 32'(target * BLOCK_WORDS * 4);
					if (wraps)
						due_results.push_back(make_result(KIND_ERASE, '0,
							{28'd0, sector_m}, 1'b0));
					for (int i = 0; i < BLOCK_WORDS; i++)
						due_results.push_back(make_result(KIND_PROGRAM,
							blk_addr + 32'(4 * i), cache_m[i],
							wraps && (i == BLOCK_WORDS - 1)));
					if (!wraps) begin
						due_results.push_back(make_result(KIND_PROGRAM,
							base_m + {24'd0, slot_m, 2'b00}, '0, 1'b1));
						slot_m = slot_m + 6'd1;
					end else begin
						slot_m = '0;
					end
					dirty_m = 1'b0;
				end
			end
		endcase
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				predict_request(request);
			if (!start || !busy) begin
				if (req_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
					start <= 1'b1;
					request <= req_backlog.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		n_bad++;
		if (n_bad <= 100)
			$display("MISMATCH result %0d %s: got %h expected %h at %0t",
				n_seen, what, got, want, $realtime);
	endtask

	always @(posedge clk) begin : mon
		res_t want;
		if (arst_n && result_valid) begin
			if (due_results.size() == 0) begin
				flag_mismatch("unexpected result, payload", result.payload, '0);
			end else begin
				want = due_results.pop_front();
				if (result.kind !== want.kind)
					flag_mismatch("kind", 32'(result.kind), 32'(want.kind));
				if (result.flash_address !== want.flash_address)
					flag_mismatch("flash_address", result.flash_address,
						want.flash_address);
				if (result.payload !== want.payload)
					flag_mismatch("payload", result.payload, want.payload);
				if (result.last !== want.last)
					flag_mismatch("last", 32'(result.last), 32'(want.last));
			end
			n_seen++;
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no activity for %0d cycles", STALL_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	task automatic push_item(input op_t op, input logic [7:0] idx,
			input logic [31:0] val);
		req_t r;
		r.req_type = op;
		r.word_index = idx;
		r.word_value = val;
		req_backlog.push_back(r);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_FLASH_BASE: base_m = data;
			CFG_INITIAL_SLOT: slot_m = {1'b0, data[4:0]};
			CFG_ERASE_SECTOR: sector_m = data[3:0];
			default: ;
		endcase
	endtask

	task automatic setup_phase(input logic [31:0] base, input logic [4:0] slot0,
			input logic [3:0] sector);
		write_reg(CFG_FLASH_BASE, base);
		write_reg(CFG_INITIAL_SLOT, {27'd0, slot0});
		write_reg(CFG_ERASE_SECTOR, {28'd0, sector});
	endtask

	// wait until every item is taken and every result is in
	task automatic drain();
		do @(negedge clk);
		while (req_backlog.size() != 0 || start || due_results.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic random_phase(input int count);
		int pick;
		logic [7:0] idx;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			idx = ($urandom_range(99) < 80) ? 8'($urandom_range(BLOCK_WORDS - 1))
				: 8'($urandom_range(255));
			if (pick < 40)
				push_item(OP_READ, idx, $urandom);
			else if (pick < 80)
				push_item(OP_WRITE, idx, $urandom);
			else if (pick < 88)
				push_item(OP_LOAD, idx, $urandom);
			else
				push_item(OP_FLUSH, idx, $urandom);
		end
		drain();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// mount: fill the whole block before anything reads it
		gap_pct = 12;
		setup_phase(32'h0000_0000, 5'd0, 4'd11);
		for (int i = 0; i < BLOCK_WORDS; i++)
			push_item(OP_LOAD, 8'(i), $urandom);
		push_item(OP_READ, 8'd0, '0);
		push_item(OP_READ, 8'd31, '0);
		push_item(OP_READ, 8'd32, '1);
		push_item(OP_READ, 8'd255, '0);
		push_item(OP_FLUSH, 8'd0, '0);
		push_item(OP_LOAD, 8'd7, 32'hFFFF_FFFF);
		push_item(OP_LOAD, 8'd255, 32'h1234_5678);
		push_item(OP_FLUSH, 8'd255, '1);
		push_item(OP_WRITE, 8'd32, 32'hDEAD_BEEF);
		push_item(OP_WRITE, 8'd255, 32'hFFFF_FFFF);
		push_item(OP_FLUSH, 8'd0, '0);
		push_item(OP_WRITE, 8'd0, 32'hFFFF_FFFF);
		push_item(OP_WRITE, 8'd31, 32'h0000_0000);
		push_item(OP_READ, 8'd0, '0);
		push_item(OP_READ, 8'd31, '0);
		push_item(OP_FLUSH, 8'd0, '0);
		push_item(OP_FLUSH, 8'd0, '0);
		drain();

		// top of sector: marker address wraps, then a full-sector erase
		setup_phase(32'hFFFF_FFFF, 5'd29, 4'd0);
		push_item(OP_WRITE, 8'd1, $urandom);
		push_item(OP_FLUSH, 8'd0, '0);
		push_item(OP_WRITE, 8'd2, $urandom);
		push_item(OP_FLUSH, 8'd0, '0);
		push_item(OP_READ, 8'd2, '0);
		push_item(OP_WRITE, 8'd0, $urandom);
		push_item(OP_FLUSH, 8'd0, '0);
		drain();

		// slot past the end of the sector
		setup_phase(32'h0000_0000, 5'd31, 4'd11);
		push_item(OP_WRITE, 8'd30, $urandom);
		push_item(OP_FLUSH, 8'd0, '0);
		drain();

		gap_pct = 0;
		setup_phase($urandom, 5'($urandom_range(31)), 4'($urandom_range(11)));
		random_phase(40);
		gap_pct = 12;
		setup_phase($urandom, 5'd28, 4'($urandom_range(4, 7)));
		random_phase(40);
		setup_phase($urandom, 5'($urandom_range(24, 31)), 4'($urandom_range(11)));
		random_phase(40);
		setup_phase(32'hFFFF_FF00, 5'd31, 4'($urandom_range(8, 11)));
		random_phase(40);

		if (n_bad == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
